FILE: hdl/pair_overlap_removal_by_mass_assert.svh
// Assertion macros for the pair overlap removal block.
// Included by modules that check their own sequencing; no other dependencies.
`ifndef PAIR_OVERLAP_REMOVAL_BY_MASS_ASSERT_SVH
`define PAIR_OVERLAP_REMOVAL_BY_MASS_ASSERT_SVH

// hold cons in the same cycle as ante
`define POR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// hold cons in the cycle after ante
`define POR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/por_pkg.sv
// Shared types and fixed field widths for the pair overlap removal block.
// No dependencies.
package por_pkg;

   localparam int MASS_W    = 32;
   localparam int KEY_W     = 8;
   localparam int KEY_RANGE = 256;

   typedef struct packed {
      logic [MASS_W-1:0] mass;
      logic [KEY_W-1:0]  a;
      logic [KEY_W-1:0]  b;
   } pair_type;

endpackage

FILE: hdl/pair_overlap_removal_by_mass.sv
// Greedy overlap removal of mass-ordered pairs: sorted pair store, sequencer, result port.
// Depends on por_pkg and pair_overlap_removal_by_mass_assert.svh.
//
//   channel   ports                                   transfer when
//   -------   -------------------------------------   ----------------------
//   request   req_pair_mass req_member_a req_member_b  start high, busy low
//             req_set_end
//   response  rsp_kept_mass rsp_kept_a rsp_kept_b      rsp_valid high
//             rsp_run_end rsp_overflowed
//
// A pair is inserted into the store in mass order through the single read port of the store,
// shifting every lighter stored pair down one place; a pair sent to a full store is dropped.
// On the closing pair, the greedy pass reads each candidate and then each earlier entry
// up to the first kept entry it conflicts with; emission then walks the store.
// busy is high while a pair is inserted and after the closing pair until the store is walked;
// reset is synchronous. Results are presented for one cycle each and cannot be stalled.
`include "pair_overlap_removal_by_mass_assert.svh"

module pair_overlap_removal_by_mass #(
   parameter int MAX_PAIRS = 16,
   parameter int KEY_SLOTS = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [por_pkg::MASS_W-1:0] req_pair_mass,
   input  logic [por_pkg::KEY_W-1:0]  req_member_a,
   input  logic [por_pkg::KEY_W-1:0]  req_member_b,
   input  logic                       req_set_end,
   output logic                       rsp_valid,
   output logic [por_pkg::MASS_W-1:0] rsp_kept_mass,
   output logic [por_pkg::KEY_W-1:0]  rsp_kept_a,
   output logic [por_pkg::KEY_W-1:0]  rsp_kept_b,
   output logic                       rsp_run_end,
   output logic                       rsp_overflowed
);

   localparam int IDX_W  = $clog2(MAX_PAIRS);
   localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
   localparam int SLOT_W = (KEY_SLOTS >= por_pkg::KEY_RANGE) ? por_pkg::KEY_W
                                                            : $clog2(KEY_SLOTS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_PASS_RD,
      ST_PASS_CAND,
      ST_CHECK,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

   state_type                   state_ff, state_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        ovf_ff, ovf_in;
   logic                        end_ff, end_in;
   por_pkg::pair_type           new_ff, new_in;
   logic [IDX_W-1:0]            pos_ff, pos_in;
   logic [IDX_W-1:0]            i_ff, i_in;
   logic [IDX_W-1:0]            j_ff, j_in;
   logic [IDX_W-1:0]            last_ff, last_in;
   logic [MAX_PAIRS-1:0]        kept_ff, kept_in;
   logic [SLOT_W-1:0]           cand_a_ff, cand_a_in;
   logic [SLOT_W-1:0]           cand_b_ff, cand_b_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [por_pkg::MASS_W-1:0]  rsp_kept_mass_ff, rsp_kept_mass_in;
   logic [por_pkg::KEY_W-1:0]   rsp_kept_a_ff, rsp_kept_a_in;
   logic [por_pkg::KEY_W-1:0]   rsp_kept_b_ff, rsp_kept_b_in;
   logic                        rsp_run_end_ff, rsp_run_end_in;
   logic                        rsp_overflowed_ff, rsp_overflowed_in;

   por_pkg::pair_type           store_mem [MAX_PAIRS];
   por_pkg::pair_type           rd_data_ff;
   logic [IDX_W-1:0]            rd_addr;
   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   por_pkg::pair_type           wr_data;

   logic [SLOT_W-1:0]           slot_lut [por_pkg::KEY_RANGE];
   logic [SLOT_W-1:0]           rd_slot_a;
   logic [SLOT_W-1:0]           rd_slot_b;
   logic                        conflict;
   logic                        accept;
   logic                        i_last;
   logic                        j_last;

   for (genvar k = 0; k < por_pkg::KEY_RANGE; k++) begin : g_slot
      assign slot_lut[k] = SLOT_W'(k % KEY_SLOTS);
   end

   assign accept    = start && !busy;
   assign rd_slot_a = slot_lut[rd_data_ff.a];
   assign rd_slot_b = slot_lut[rd_data_ff.b];
   assign conflict  = (rd_slot_a == cand_a_ff) || (rd_slot_a == cand_b_ff) ||
                      (rd_slot_b == cand_a_ff) || (rd_slot_b == cand_b_ff);
   assign i_last    = (CNT_W'(i_ff) + CNT_W'(1)) == count_ff;
   assign j_last    = (CNT_W'(j_ff) + CNT_W'(1)) == count_ff;

   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      ovf_in            = ovf_ff;
      end_in            = end_ff;
      new_in            = new_ff;
      pos_in            = pos_ff;
      i_in              = i_ff;
      j_in              = j_ff;
      last_in           = last_ff;
      kept_in           = kept_ff;
      cand_a_in         = cand_a_ff;
      cand_b_in         = cand_b_ff;
      rsp_valid_in      = 1'b0;
      rsp_kept_mass_in  = rsp_kept_mass_ff;
      rsp_kept_a_in     = rsp_kept_a_ff;
      rsp_kept_b_in     = rsp_kept_b_ff;
      rsp_run_end_in    = rsp_run_end_ff;
      rsp_overflowed_in = rsp_overflowed_ff;
      rd_addr           = '0;
      wr_en             = 1'b0;
      wr_addr           = pos_ff;
      wr_data           = new_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               new_in.mass = req_pair_mass;
               new_in.a    = req_member_a;
               new_in.b    = req_member_b;
               end_in      = req_set_end;
               if (count_ff == CNT_W'(MAX_PAIRS)) begin
                  ovf_in = 1'b1;
                  if (req_set_end) begin
                     i_in     = '0;
                     state_in = ST_PASS_RD;
                  end
               end else begin
                  pos_in = count_ff[IDX_W-1:0];
                  if (count_ff == '0) begin
                     state_in = ST_INS_PUT;
                  end else begin
                     rd_addr  = count_ff[IDX_W-1:0] - 1'b1;
                     state_in = ST_INS_CMP;
                  end
               end
            end
         end
         ST_INS_CMP: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            if (rd_data_ff.mass < new_ff.mass) begin
               wr_data = rd_data_ff;
               pos_in  = pos_ff - 1'b1;
               if (pos_ff == IDX_W'(1)) begin
                  state_in = ST_INS_PUT;
               end else begin
                  rd_addr = pos_ff - 1'b1 - 1'b1;
               end
            end else begin
               wr_data  = new_ff;
               count_in = count_ff + 1'b1;
               i_in     = '0;
               state_in = end_ff ? ST_PASS_RD : ST_IDLE;
            end
         end
         ST_INS_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = new_ff;
            count_in = count_ff + 1'b1;
            i_in     = '0;
            state_in = end_ff ? ST_PASS_RD : ST_IDLE;
         end
         ST_PASS_RD: begin
            rd_addr  = i_ff;
            state_in = ST_PASS_CAND;
         end
         ST_PASS_CAND: begin
            cand_a_in = rd_slot_a;
            cand_b_in = rd_slot_b;
            j_in      = '0;
            rd_addr   = '0;
            if (i_ff == '0) begin
               kept_in[i_ff] = 1'b1;
               last_in       = i_ff;
               if (i_last) begin
                  state_in = ST_EMIT_RD;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_PASS_RD;
               end
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (kept_ff[j_ff] && conflict) begin
               if (i_last) begin
                  state_in = ST_EMIT_RD;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_PASS_RD;
               end
            end else if ((j_ff + 1'b1) == i_ff) begin
               kept_in[i_ff] = 1'b1;
               last_in       = i_ff;
               if (i_last) begin
                  state_in = ST_EMIT_RD;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_PASS_RD;
               end
            end else begin
               j_in    = j_ff + 1'b1;
               rd_addr = j_ff + 1'b1;
            end
         end
         ST_EMIT_RD: begin
            j_in     = '0;
            rd_addr  = '0;
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (kept_ff[j_ff]) begin
               rsp_valid_in      = 1'b1;
               rsp_kept_mass_in  = rd_data_ff.mass;
               rsp_kept_a_in     = rd_data_ff.a;
               rsp_kept_b_in     = rd_data_ff.b;
               rsp_run_end_in    = (j_ff == last_ff);
               rsp_overflowed_in = ovf_ff;
            end
            if (j_last) begin
               count_in = '0;
               ovf_in   = 1'b0;
               kept_in  = '0;
               state_in = ST_IDLE;
            end else begin
               j_in    = j_ff + 1'b1;
               rd_addr = j_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      end_ff            <= end_in;
      new_ff            <= new_in;
      pos_ff            <= pos_in;
      i_ff              <= i_in;
      j_ff              <= j_in;
      last_ff           <= last_in;
      cand_a_ff         <= cand_a_in;
      cand_b_ff         <= cand_b_in;
      rsp_kept_mass_ff  <= rsp_kept_mass_in;
      rsp_kept_a_ff     <= rsp_kept_a_in;
      rsp_kept_b_ff     <= rsp_kept_b_in;
      rsp_run_end_ff    <= rsp_run_end_in;
      rsp_overflowed_ff <= rsp_overflowed_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         kept_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         kept_ff      <= kept_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kept_mass  = rsp_kept_mass_ff;
   assign rsp_kept_a     = rsp_kept_a_ff;
   assign rsp_kept_b     = rsp_kept_b_ff;
   assign rsp_run_end    = rsp_run_end_ff;
   assign rsp_overflowed = rsp_overflowed_ff;

   `POR_ASSERT_NEXT(a_final_then_quiet, clock, reset, rsp_valid_ff && rsp_run_end_ff,
                    !rsp_valid_ff, "result followed the final result of a set")
   `POR_ASSERT_NOW(a_more_follow, clock, reset, rsp_valid_ff && !rsp_run_end_ff,
                   state_ff == ST_EMIT_OUT, "non-final result left emission")
   `POR_ASSERT_NOW(a_heaviest_kept, clock, reset, state_ff == ST_EMIT_OUT,
                   kept_ff[0], "heaviest pair not kept")
   `POR_ASSERT_NOW(a_idle_clean, clock, reset, state_ff == ST_IDLE,
                   kept_ff == '0, "kept flags not cleared in idle")
   `POR_ASSERT_NEXT(a_close_busy, clock, reset, accept && req_set_end,
                    busy, "closing transfer did not start the pass")

endmodule
